// ===== hdl/bfpt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfpt_pkg - shared types and constants for the best fit predecessor take
// Capacity, value width, channel payloads, operation and status codes, and
// the link that each cell of the sorted chain shows its neighbors.
// ----------------------------------------------------------------------------
package bfpt_pkg;

	// store geometry
	localparam int CAPACITY    = 256;
	localparam int VALUE_BITS  = 30;
	localparam int FIELD_BITS  = 30;
	localparam int GROUP_CELLS = 16;
	localparam int NUM_GROUPS  = (CAPACITY + GROUP_CELLS - 1) / GROUP_CELLS;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_TAKE   = 1'b1;

	// status codes
	localparam logic [1:0] ST_TAKEN    = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_INSERTED = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef logic [VALUE_BITS-1:0] val_t;

	typedef struct packed {
		logic                  operation;
		logic [FIELD_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [FIELD_BITS-1:0] taken_value;
	} rsp_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic vld;
		logic le;
		val_t val;
	} link_t;

	// chain summary toward the control
	typedef struct packed {
		logic found;
		logic full;
	} chain_stat_t;

	// field value to store width, masking the high bits
	function automatic val_t to_val(input logic [FIELD_BITS-1:0] f);
		val_t r;
		r = '0;
		for (int i = 0; i < VALUE_BITS; i++) begin
			if (i < FIELD_BITS) begin
				r[i] = f[i];
			end
		end
		return r;
	endfunction

	// store value to field width
	function automatic logic [FIELD_BITS-1:0] to_field(input val_t v);
		logic [FIELD_BITS-1:0] r;
		r = '0;
		for (int i = 0; i < FIELD_BITS; i++) begin
			if (i < VALUE_BITS) begin
				r[i] = v[i];
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/bfpt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfpt_cell - one slot of the sorted chain
// Holds one value and its occupancy, compares it with the item value and
// shifts right on insert or left on take, based on the neighbor compares.
// ----------------------------------------------------------------------------
module bfpt_cell import bfpt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  go,
	input  wire logic  op,
	input  wire val_t  value,
	input  wire link_t left,
	input  wire link_t right,
	output link_t      link,
	output val_t       taken_part
);

	val_t val_q;
	logic vld_q;
	logic le;

	// compare against the item value
	always_comb begin
		le = vld_q && (val_q <= value);
		link = '{vld: vld_q, le: le, val: val_q};
		taken_part = (op == OP_TAKE && le && !right.le) ? val_q : '0;
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (go) begin
			if (op == OP_INSERT) begin
				if (!le) begin
					vld_q <= left.le ? 1'b1 : left.vld;
				end
			end else if (!right.le) begin
				vld_q <= right.vld;
			end
		end
	end

	// stored value
	always_ff @(posedge clk) begin
		if (go) begin
			if (op == OP_INSERT) begin
				if (!le) begin
					val_q <= left.le ? value : left.val;
				end
			end else if (!right.le) begin
				val_q <= right.val;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/bfpt_chain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfpt_chain - row of sorted cells and taken value collection
// Wires the cells to their neighbors, reports found and full, and gathers
// the selected cell's value into registered groups.
// ----------------------------------------------------------------------------
module bfpt_chain import bfpt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic               op,
	input  wire val_t               value,
	output chain_stat_t             stat,
	output val_t [NUM_GROUPS-1:0]   group_s1
);

	link_t links [CAPACITY];
	val_t  parts [CAPACITY];
	val_t [NUM_GROUPS-1:0] group_or;

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		link_t left_l;
		link_t right_l;
		if (i == 0) begin : g_first
			assign left_l = '{vld: 1'b1, le: 1'b1, val: '0};
		end else begin : g_mid_l
			assign left_l = links[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_l = '0;
		end else begin : g_mid_r
			assign right_l = links[i+1];
		end
		bfpt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.go        (go),
			.op        (op),
			.value     (value),
			.left      (left_l),
			.right     (right_l),
			.link      (links[i]),
			.taken_part(parts[i])
		);
	end

	// summary flags
	assign stat = '{found: links[0].le, full: links[CAPACITY-1].vld};

	// per group collection of the selected value
	always_comb begin
		group_or = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			for (int k = 0; k < GROUP_CELLS; k++) begin
				if (g * GROUP_CELLS + k < CAPACITY) begin
					group_or[g] = group_or[g] | parts[g * GROUP_CELLS + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		group_s1 <= group_or;
	end

	// checking views of the row
	logic [CAPACITY-1:0] vld_vec;
	logic [CAPACITY-1:0] sel_vec;
	logic [CAPACITY-1:0] order_bad;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			vld_vec[i] = links[i].vld;
			sel_vec[i] = (parts[i] != '0);
			order_bad[i] = 1'b0;
			if (i + 1 < CAPACITY) begin
				order_bad[i] = links[(i + 1) % CAPACITY].vld &&
					(links[i].val > links[(i + 1) % CAPACITY].val);
			end
		end
	end

	// occupied cells form a prefix
	assert property (@(posedge clk) disable iff (!arst_n)
		((vld_vec >> 1) & ~vld_vec) == '0)
		else $error("chain occupancy has a hole");

	// occupied cells stay in ascending order
	assert property (@(posedge clk) disable iff (!arst_n) order_bad == '0)
		else $error("chain out of order");

	// at most one cell offers a nonzero taken value
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(sel_vec))
		else $error("more than one cell selected for take");

endmodule
`default_nettype wire

// ===== hdl/best_fit_predecessor_take.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_predecessor_take - sorted multiset with best fit predecessor take
// Top level: request handshake, status decision, result collection and the
// output register.
// ----------------------------------------------------------------------------
// The store is a row of CAPACITY cells kept in ascending order. Every cell
// compares its value with the request in the transfer cycle and the row
// shifts right to open a slot on insert, or left to close the gap on take,
// so the store is updated at the end of that cycle; a full store on insert
// or a take with no fit leaves it as it is. The taken value is then
// gathered in one registered group stage and one final stage into the
// response register. The response is valid once the request has passed
// the status stage and the response register. Only one request is in
// flight, so a new request can transfer in the cycle the previous response
// is taken; a stalled response holds off the next request. No clearing
// pass is needed after reset.
module best_fit_predecessor_take import bfpt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	chain_stat_t           stat;
	val_t [NUM_GROUPS-1:0] group_s1;
	logic                  accept;
	logic                  go;
	logic                  s1_valid_q;
	logic [1:0]            status_s1;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	val_t                  taken;

	// one request in flight at a time
	assign req_ready = !s1_valid_q && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign go        = accept && ((req.operation == OP_INSERT) ? !stat.full : stat.found);

	bfpt_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.op      (req.operation),
		.value   (to_val(req.value)),
		.stat    (stat),
		.group_s1(group_s1)
	);

	// status stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req.operation == OP_INSERT) begin
				status_s1 <= stat.full ? ST_FULL : ST_INSERTED;
			end else begin
				status_s1 <= stat.found ? ST_TAKEN : ST_NO_FIT;
			end
		end
	end

	// final gathering of the group values
	always_comb begin
		taken = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			taken = taken | group_s1[g];
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_valid_q) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			rsp_q.status      <= status_s1;
			rsp_q.taken_value <= to_field(taken);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// no new request while one is still in the status stage
	assert property (@(posedge clk) disable iff (!arst_n) accept |-> !s1_valid_q)
		else $error("request accepted while status stage busy");

	// the status stage always finds the response register free
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> (!rsp_valid_q || rsp_ready))
		else $error("status stage would overwrite a pending response");

	// only a successful take carries a value
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != ST_TAKEN) |-> (rsp_q.taken_value == '0))
		else $error("nonzero value on a response that took nothing");

endmodule
`default_nettype wire
